>>> hdl/pbf_pkg.sv
// package for the pixel blend and format unit
// types, register codes and small arithmetic helpers; no dependencies
package pbf_pkg;

    localparam int PIXEL_W = 32;
    localparam int CHAN_W  = 8;
    localparam int MODE_W  = 3;
    localparam int FMT_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_BLEND_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'b1;

    localparam logic [MODE_W-1:0] MODE_OPAQUE       = 3'd0;
    localparam logic [MODE_W-1:0] MODE_BLEND        = 3'd1;
    localparam logic [MODE_W-1:0] MODE_PREMUL_BLEND = 3'd2;
    localparam logic [MODE_W-1:0] MODE_SWAP_RB      = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PREMULTIPLY  = 3'd4;
    localparam logic [MODE_W-1:0] MODE_RESET        = MODE_OPAQUE;

    typedef enum logic [FMT_W-1:0] {
        FMT_GRAY8    = 2'd0,
        FMT_ARGB4444 = 2'd1,
        FMT_RGB888   = 2'd2,
        FMT_ARGB8888 = 2'd3
    } fmt_t;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'hff;

    typedef struct packed {
        logic [CHAN_W-1:0] a;
        logic [CHAN_W-1:0] r;
        logic [CHAN_W-1:0] g;
        logic [CHAN_W-1:0] b;
    } argb_t;

    typedef struct packed {
        argb_t pix;
        logic  sat;
    } blend_out_t;

    // 8 x 8 product
    function automatic logic [15:0] mul8(input logic [CHAN_W-1:0] x,
                                         input logic [CHAN_W-1:0] y);
        return 16'(x) * 16'(y);
    endfunction

    // exact x / 255 for x up to 255 * 255
    function automatic logic [CHAN_W-1:0] div255(input logic [15:0] x);
        logic [16:0] sum;
        sum = 17'(x) + 17'(x[15:8]) + 17'd1;
        return sum[15:8];
    endfunction

    function automatic logic [PIXEL_W-1:0] pack(input argb_t c, input fmt_t fmt);
        logic [PIXEL_W-1:0] res;
        unique case (fmt)
            FMT_GRAY8:    res = {24'd0, c.b};
            FMT_ARGB4444: res = {16'd0, c.a[7:4], c.r[7:4], c.g[7:4], c.b[7:4]};
            FMT_RGB888:   res = {8'd0, c.r, c.g, c.b};
            FMT_ARGB8888: res = c;
            default:      res = c;
        endcase
        return res;
    endfunction

endpackage

>>> hdl/pbf_unpack.sv
// widens one stored-format pixel to argb8888
// depends on pbf_pkg
module pbf_unpack
    import pbf_pkg::*;
(
    input  fmt_t               fmt,
    input  logic [PIXEL_W-1:0] pixel,
    output argb_t              argb
);

    // nibble times 17
    function automatic logic [CHAN_W-1:0] widen(input logic [3:0] n);
        return {n, n};
    endfunction

    always_comb begin
        unique case (fmt)
            FMT_GRAY8: begin
                argb = {CHAN_MAX, pixel[7:0], pixel[7:0], pixel[7:0]};
            end
            FMT_ARGB4444: begin
                argb = {widen(pixel[15:12]), widen(pixel[11:8]),
                        widen(pixel[7:4]), widen(pixel[3:0])};
            end
            FMT_RGB888: begin
                argb = {CHAN_MAX, pixel[23:0]};
            end
            default: begin
                argb = pixel;
            end
        endcase
    end

endmodule

>>> hdl/pbf_blend.sv
// applies the blend mode to unpacked source and destination pixels
// depends on pbf_pkg
module pbf_blend
    import pbf_pkg::*;
(
    input  logic [MODE_W-1:0] mode,
    input  argb_t             src,
    input  argb_t             dst,
    output blend_out_t        res
);

    logic [CHAN_W-1:0] inv;
    logic [CHAN_W-1:0] out_a;
    logic [CHAN_W-1:0] bl_r, bl_g, bl_b;
    logic [CHAN_W-1:0] pm_r, pm_g, pm_b;
    logic              sat_r, sat_g, sat_b;
    logic [CHAN_W-1:0] pa_r, pa_g, pa_b;

    function automatic logic [CHAN_W-1:0] mix(input logic [CHAN_W-1:0] s,
                                              input logic [CHAN_W-1:0] sa,
                                              input logic [CHAN_W-1:0] d,
                                              input logic [CHAN_W-1:0] ia);
        logic [16:0] sum;
        sum = 17'(mul8(s, sa)) + 17'(mul8(d, ia));
        return div255(sum[15:0]);
    endfunction

    // premultiplied channel, bit 8 marks overflow
    function automatic logic [CHAN_W:0] pmix(input logic [CHAN_W-1:0] s,
                                             input logic [CHAN_W-1:0] d,
                                             input logic [CHAN_W-1:0] ia);
        return 9'(s) + 9'(div255(mul8(d, ia)));
    endfunction

    function automatic logic [CHAN_W-1:0] clamp(input logic [CHAN_W:0] v);
        return v[CHAN_W] ? CHAN_MAX : v[CHAN_W-1:0];
    endfunction

    logic [CHAN_W:0] pv_r, pv_g, pv_b;

    always_comb begin
        inv   = CHAN_MAX - src.a;
        out_a = mix(src.a, src.a, dst.a, inv);
        bl_r  = mix(src.r, src.a, dst.r, inv);
        bl_g  = mix(src.g, src.a, dst.g, inv);
        bl_b  = mix(src.b, src.a, dst.b, inv);
        pv_r  = pmix(src.r, dst.r, inv);
        pv_g  = pmix(src.g, dst.g, inv);
        pv_b  = pmix(src.b, dst.b, inv);
        pm_r  = clamp(pv_r);
        pm_g  = clamp(pv_g);
        pm_b  = clamp(pv_b);
        sat_r = pv_r[CHAN_W];
        sat_g = pv_g[CHAN_W];
        sat_b = pv_b[CHAN_W];
        pa_r  = div255(mul8(dst.r, dst.a));
        pa_g  = div255(mul8(dst.g, dst.a));
        pa_b  = div255(mul8(dst.b, dst.a));

        res.sat = 1'b0;
        unique case (mode)
            MODE_OPAQUE: begin
                res.pix = src;
            end
            MODE_BLEND: begin
                res.pix = {out_a, bl_r, bl_g, bl_b};
            end
            MODE_PREMUL_BLEND: begin
                res.pix = {out_a, pm_r, pm_g, pm_b};
                res.sat = sat_r | sat_g | sat_b;
            end
            MODE_SWAP_RB: begin
                res.pix = {dst.a, dst.b, dst.g, dst.r};
            end
            MODE_PREMULTIPLY: begin
                res.pix = {dst.a, pa_r, pa_g, pa_b};
            end
            default: begin
                res.pix = dst;
            end
        endcase
    end

endmodule

>>> hdl/pixel_blend_format_unit.sv
// Pixel blend and format unit. One source/destination pixel pair is taken per
// clock while s_ready is high. The accepted pair is held in the input register and
// the packed result in the result register behind the m_ ports; unpack, blend and
// repack are done in the single pass between the two registers. Throughput
// is one pixel per clock for as long as m_ready stays high; a stalled result is held
// while one more pair waits in the input register. blend_mode (index 0) and
// pixel_format (index 1) are written through the cfg port, always ready, and reset
// to opaque and ARGB8888.
// top level; depends on pbf_pkg, pbf_unpack and pbf_blend
module pixel_blend_format_unit
    import pbf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [PIXEL_W-1:0]    s_src_pixel,
    input  logic [PIXEL_W-1:0]    s_dest_pixel,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [PIXEL_W-1:0]    m_result_pixel,
    output logic                  m_saturated
);

    logic [MODE_W-1:0]  mode_reg, mode_next;
    fmt_t               fmt_reg, fmt_next;
    logic               in_valid_reg, in_valid_next;
    logic [PIXEL_W-1:0] src_reg, dest_reg;
    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] result_reg;
    logic               sat_reg;
    logic               out_load;
    argb_t              src_argb, dst_argb;
    blend_out_t         blend_res;

    assign cfg_ready = 1'b1;

    always_comb begin
        mode_next = mode_reg;
        fmt_next  = fmt_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_BLEND_MODE:   mode_next = cfg_data;
                REG_PIXEL_FORMAT: fmt_next  = fmt_t'(cfg_data[FMT_W-1:0]);
                default:          mode_next = mode_reg;
            endcase
        end
    end

    assign out_load       = !out_valid_reg || m_ready;
    assign s_ready        = !in_valid_reg || out_load;
    assign in_valid_next  = s_ready ? s_valid : in_valid_reg;
    assign out_valid_next = out_load ? in_valid_reg : out_valid_reg;

    pbf_unpack u_unpack_src (
        .fmt   (fmt_reg),
        .pixel (src_reg),
        .argb  (src_argb)
    );

    pbf_unpack u_unpack_dst (
        .fmt   (fmt_reg),
        .pixel (dest_reg),
        .argb  (dst_argb)
    );

    pbf_blend u_blend (
        .mode (mode_reg),
        .src  (src_argb),
        .dst  (dst_argb),
        .res  (blend_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= MODE_RESET;
            fmt_reg       <= FMT_ARGB8888;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            mode_reg      <= mode_next;
            fmt_reg       <= fmt_next;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            src_reg  <= s_src_pixel;
            dest_reg <= s_dest_pixel;
        end
        if (in_valid_reg && out_load) begin
            result_reg <= pack(blend_res.pix, fmt_reg);
            sat_reg    <= blend_res.sat;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_result_pixel = result_reg;
    assign m_saturated    = sat_reg;

`ifndef SYNTHESIS
    a_sat_only_premul: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |-> mode_reg == MODE_PREMUL_BLEND)
        else $error("saturation flag outside premultiplied blend");

    a_gray_high_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && fmt_reg == FMT_GRAY8 |-> m_result_pixel[PIXEL_W-1:CHAN_W] == '0)
        else $error("gray result has high bits set");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !out_valid_reg |-> s_ready)
        else $error("input stalled with empty result register");

    a_hold_input: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !s_ready |=> in_valid_reg && $stable(src_reg))
        else $error("pending transaction lost from input register");

    a_opaque_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && out_load && mode_reg == MODE_OPAQUE && fmt_reg == FMT_ARGB8888
        |=> m_result_pixel == $past(src_reg))
        else $error("opaque copy mismatch");
`endif

endmodule

>>> tb/pbf_blend_checker.sv
`timescale 1ns / 100ps
// checker for the pixel blend and format unit: watches the config, pixel and result channels
// and compares every result against its own blend prediction; depends on pbf_pkg
module pbf_blend_checker
    import pbf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  logic [PIXEL_W-1:0]    s_src_pixel,
    input  logic [PIXEL_W-1:0]    s_dest_pixel,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  logic [PIXEL_W-1:0]    m_result_pixel,
    input  logic                  m_saturated,
    output int                    fail_count,
    output int                    outstanding
);

    localparam int MAX_REPORTS = 10;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel;
        logic               sat;
    } blend_result_t;

    blend_result_t     pending_results[$];
    logic [MODE_W-1:0] cur_mode;
    fmt_t              cur_fmt;

    function automatic argb_t widen(input logic [PIXEL_W-1:0] p, input fmt_t fmt);
        argb_t c;
        case (fmt)
            FMT_GRAY8:    c = {CHAN_MAX, p[7:0], p[7:0], p[7:0]};
            FMT_ARGB4444: c = {{2{p[15:12]}}, {2{p[11:8]}}, {2{p[7:4]}}, {2{p[3:0]}}};
            FMT_RGB888:   c = {CHAN_MAX, p[23:0]};
            default:      c = p;
        endcase
        return c;
    endfunction

    function automatic logic [PIXEL_W-1:0] narrow(input argb_t c, input fmt_t fmt);
        logic [PIXEL_W-1:0] p;
        p = '0;
        case (fmt)
            FMT_GRAY8:    p[7:0] = c.b;
            FMT_ARGB4444: p[15:0] = {c.a[7:4], c.r[7:4], c.g[7:4], c.b[7:4]};
            FMT_RGB888:   p[23:0] = c[23:0];
            default:      p = c;
        endcase
        return p;
    endfunction

    function automatic blend_result_t blend_pixel(input logic [PIXEL_W-1:0] src,
                                                  input logic [PIXEL_W-1:0] dest,
                                                  input logic [MODE_W-1:0]  mode,
                                                  input fmt_t               fmt);
        argb_t         s;
        argb_t         d;
        argb_t         o;
        int            full;
        int            inv;
        int            v;
        blend_result_t res;
        full = int'(CHAN_MAX);
        s = widen(src, fmt);
        d = widen(dest, fmt);
        inv = full - int'(s.a);
        o = d;
        res.sat = 1'b0;
        case (mode)
            MODE_OPAQUE: o = s;
            MODE_BLEND, MODE_PREMUL_BLEND: begin
                for (int k = 0; k < 4; k++) begin
                    v = int'(s[8*k +: 8]) * int'(s.a) + int'(d[8*k +: 8]) * inv;
                    o[8*k +: 8] = 8'(v / full);
                end
                if (mode == MODE_PREMUL_BLEND) begin
                    // colour only, alpha keeps the plain blend value
                    for (int k = 0; k < 3; k++) begin
                        v = int'(s[8*k +: 8]) + int'(d[8*k +: 8]) * inv / full;
                        if (v > full) begin
                            v = full;
                            res.sat = 1'b1;
                        end
                        o[8*k +: 8] = 8'(v);
                    end
                end
            end
            MODE_SWAP_RB: o = {d.a, d.b, d.g, d.r};
            MODE_PREMULTIPLY: begin
                for (int k = 0; k < 3; k++) begin
                    o[8*k +: 8] = 8'(int'(d[8*k +: 8]) * int'(d.a) / full);
                end
            end
            default: o = d;
        endcase
        res.pixel = narrow(o, fmt);
        return res;
    endfunction

    task automatic log_mismatch(input string field, input logic [PIXEL_W-1:0] want,
                                input logic [PIXEL_W-1:0] got);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t: %s mismatch, expected %h got %h", $time, field, want, got);
        end
    endtask

    always @(posedge aclk) begin
        blend_result_t want;
        if (!aresetn) begin
            cur_mode = MODE_RESET;
            cur_fmt = FMT_ARGB8888;
            pending_results.delete();
            fail_count = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS) begin
                        $display("%0t: result transaction with none expected, got %h sat %b",
                                 $time, m_result_pixel, m_saturated);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (m_result_pixel !== want.pixel) begin
                        log_mismatch("result_pixel", want.pixel, m_result_pixel);
                    end
                    if (m_saturated !== want.sat) begin
                        log_mismatch("saturated", PIXEL_W'(want.sat), PIXEL_W'(m_saturated));
                    end
                end
            end
            if (s_valid && s_ready) begin
                pending_results.push_back(blend_pixel(s_src_pixel, s_dest_pixel,
                                                      cur_mode, cur_fmt));
            end
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_BLEND_MODE:   cur_mode = cfg_data;
                    REG_PIXEL_FORMAT: cur_fmt = fmt_t'(cfg_data[FMT_W-1:0]);
                    default:          ;
                endcase
            end
        end
        outstanding = pending_results.size();
    end

endmodule

>>> tb/pixel_blend_format_unit_tb.sv
`timescale 1ns / 100ps
// top of the pixel blend and format unit testbench: clock, reset, pixel and config stimulus,
// result back-pressure and verdict; depends on pbf_pkg, pbf_blend_checker and the unit itself
module pixel_blend_format_unit_tb;
    import pbf_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int RESET_CYCLES    = 6;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int DRAIN_CYCLES    = 4;
    localparam int HOLD_CYCLES     = 200;
    localparam int IDLE_PERCENT    = 26;
    localparam int NUM_PHASES      = 25;
    localparam int ITEMS_PER_PHASE = 66;
    localparam int NUM_MODES       = MODE_PREMULTIPLY + 1;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [PIXEL_W-1:0]    s_src_pixel = '0;
    logic [PIXEL_W-1:0]    s_dest_pixel = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [PIXEL_W-1:0]    m_result_pixel;
    logic                  m_saturated;

    int fail_count;
    int outstanding;
    int cycle_count = 0;
    bit steady = 1'b0;
    bit hold_pending = 1'b0;

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    pixel_blend_format_unit u_dut (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_src_pixel, .s_dest_pixel,
        .m_valid, .m_ready, .m_result_pixel, .m_saturated
    );

    pbf_blend_checker u_checker (
        .aclk, .aresetn,
        .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
        .s_valid, .s_ready, .s_src_pixel, .s_dest_pixel,
        .m_valid, .m_ready, .m_result_pixel, .m_saturated,
        .fail_count, .outstanding
    );

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic logic [PIXEL_W-1:0] random_pixel();
        logic [PIXEL_W-1:0] p;
        p = $urandom();
        case ($urandom_range(7))
            0: p[31:24] = CHAN_MAX;
            1: p[31:24] = '0;
            2: p = '1;
            3: p = '0;
            4: p[15:12] = $urandom_range(1) ? 4'hf : 4'h0;
            default: ;
        endcase
        return p;
    endfunction

    task automatic send_pair(input logic [PIXEL_W-1:0] src, input logic [PIXEL_W-1:0] dest);
        if (!steady) begin
            while ($urandom_range(99) < IDLE_PERCENT) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_src_pixel <= src;
        s_dest_pixel <= dest;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(negedge aclk); while (outstanding != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_config(input logic [MODE_W-1:0] mode, input fmt_t fmt);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= REG_BLEND_MODE;
        cfg_data <= mode;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= REG_PIXEL_FORMAT;
        cfg_data <= CFG_DATA_W'(fmt);
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // result side back-pressure
    initial begin
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end
            m_ready <= steady || ($urandom_range(99) >= IDLE_PERCENT);
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset configuration: opaque copy, ARGB8888
        send_pair(32'hffff_ffff, 32'h0000_0000);
        send_pair(32'h0000_0000, 32'hffff_ffff);

        set_config(MODE_PREMUL_BLEND, FMT_ARGB8888);
        send_pair(32'h00ff_ffff, 32'hffff_ffff);
        send_pair(32'hff00_0000, 32'h0000_0000);
        send_pair(32'h7f80_8080, 32'hffff_ffff);

        set_config(MODE_BLEND, FMT_ARGB8888);
        send_pair(32'h80ff_0000, 32'h4000_ff00);
        send_pair(32'h0000_0000, 32'h0000_0000);
        send_pair(32'hffff_ffff, 32'hffff_ffff);

        set_config(MODE_SWAP_RB, FMT_RGB888);
        send_pair(32'ha512_3456, 32'ha5ab_cdef);

        set_config(MODE_PREMULTIPLY, FMT_ARGB8888);
        send_pair(32'h0000_0000, 32'h80ff_7f01);
        send_pair(32'h0000_0000, 32'hffff_ffff);
        send_pair(32'hffff_ffff, 32'h00ff_ffff);

        // undefined modes leave the destination as it is
        for (int m = NUM_MODES; m < (1 << MODE_W); m++) begin
            set_config(MODE_W'(m), FMT_ARGB4444);
            send_pair(32'hffff_1234, 32'habcd_9f3c);
        end

        set_config(MODE_BLEND, FMT_GRAY8);
        send_pair(32'hffff_ff80, 32'h1234_56c0);

        set_config(MODE_PREMUL_BLEND, FMT_ARGB4444);
        send_pair(32'h0000_0fff, 32'h0000_ffff);
        send_pair(32'hffff_f000, 32'h0000_0fff);

        set_config(MODE_OPAQUE, FMT_RGB888);
        send_pair(32'hff00_ff00, 32'h0000_0000);

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase < NUM_MODES * 4) begin
                set_config(MODE_W'(phase % NUM_MODES), fmt_t'(phase / NUM_MODES));
            end else begin
                set_config(MODE_W'($urandom_range((1 << MODE_W) - 1)),
                           fmt_t'($urandom_range((1 << FMT_W) - 1)));
            end
            steady = (phase == 7);
            if (phase == 12) begin
                hold_pending = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) send_pair(random_pixel(), random_pixel());
        end

        wait_drained();
        @(negedge aclk);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
